FILE: hw/rtl/irc_pkg.sv
// Shared types and constants for the input replay cache.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.

package irc_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam int SEQ_W  = 32;
    localparam int CTL_W  = 5;
    localparam int PH_W   = 2;
    localparam int REQ_W  = 2;
    localparam int VERD_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_RECORD = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req;

    typedef enum logic [VERD_W-1:0] {
        VERDICT_NEW       = 2'd0,
        VERDICT_DUPLICATE = 2'd1,
        VERDICT_CONFLICT  = 2'd2
    } t_verdict;

    // controller -> datapath
    typedef struct packed {
        logic accept;    // request transfer, latch key and restart scan
        logic record;    // write entry at write pointer
        logic clear;     // drop all valid marks, zero pointer
        logic scan;      // examine one entry
        logic load_out;  // move verdict into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hit;       // current scan entry is valid with equal sequence
        logic last;      // current scan entry is the final one
    } t_stat;

endpackage

FILE: hw/rtl/irc_req_if.sv
// Request channel for the input replay cache: valid/ready plus request payload.
// Depends on irc_pkg for field widths.

interface irc_req_if;
    logic                       valid;
    logic                       ready;
    logic [irc_pkg::REQ_W-1:0]  req_type;
    logic [irc_pkg::SEQ_W-1:0]  seq_number;
    logic [irc_pkg::CTL_W-1:0]  control_code;
    logic [irc_pkg::PH_W-1:0]   phase_code;

    modport source (output valid, req_type, seq_number, control_code, phase_code,
                    input ready);
    modport sink   (input valid, req_type, seq_number, control_code, phase_code,
                    output ready);
endinterface

FILE: hw/rtl/irc_rsp_if.sv
// Response channel for the input replay cache: valid/ready plus verdict.
// Depends on irc_pkg for field widths.

interface irc_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [irc_pkg::VERD_W-1:0]  verdict;

    modport source (output valid, verdict, input ready);
    modport sink   (input valid, verdict, output ready);
endinterface

FILE: hw/rtl/irc_ctrl.sv
// Controller FSM for the input replay cache: sequences accept, scan and result.
// Depends on irc_pkg (t_cmd, t_stat, t_req).

module irc_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [irc_pkg::REQ_W-1:0] i_req_type,
    input  logic                      i_out_ready,
    input  irc_pkg::t_stat            i_stat,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    output irc_pkg::t_cmd             o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_slot_free;

    // no transfer while reset is held
    assign o_in_ready  = i_rst_n && (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.accept   = w_accept;
        o_cmd.record   = w_accept && (i_req_type == irc_pkg::REQ_RECORD);
        o_cmd.clear    = w_accept && (i_req_type == irc_pkg::REQ_CLEAR);
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_req_type == irc_pkg::REQ_LOOKUP) ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.hit || i_stat.last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    // never overwrite a result the receiver has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while occupied");

    // a lookup transfer always starts a scan
    a_lookup_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req_type == irc_pkg::REQ_LOOKUP)) |=> (r_state == ST_SCAN))
        else $error("lookup did not enter scan");

    // scan ends on the first hit
    a_hit_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && i_stat.hit) |=> (r_state == ST_FINISH))
        else $error("scan continued past a hit");

    // only one result per request: output loads only from FINISH
    a_load_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> (r_state == ST_IDLE && r_out_valid))
        else $error("result load without return to idle");
`endif

endmodule

FILE: hw/rtl/irc_dpath.sv
// Datapath for the input replay cache: entry table, write pointer, scan index,
// verdict and output register. Depends on irc_pkg.

module irc_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  irc_pkg::t_cmd               i_cmd,
    input  logic [irc_pkg::SEQ_W-1:0]   i_seq_number,
    input  logic [irc_pkg::CTL_W-1:0]   i_control_code,
    input  logic [irc_pkg::PH_W-1:0]    i_phase_code,
    output irc_pkg::t_stat              o_stat,
    output logic [irc_pkg::VERD_W-1:0]  o_verdict
);

    localparam logic [irc_pkg::IDX_W-1:0] LAST_IDX = irc_pkg::IDX_W'(irc_pkg::CAPACITY - 1);

    logic [irc_pkg::CAPACITY-1:0] r_valid;
    logic [irc_pkg::SEQ_W-1:0]    r_seq [irc_pkg::CAPACITY];
    logic [irc_pkg::CTL_W-1:0]    r_ctl [irc_pkg::CAPACITY];
    logic [irc_pkg::PH_W-1:0]     r_ph  [irc_pkg::CAPACITY];

    logic [irc_pkg::IDX_W-1:0]    r_wptr;
    logic [irc_pkg::IDX_W-1:0]    r_idx;
    logic [irc_pkg::SEQ_W-1:0]    r_key_seq;
    logic [irc_pkg::CTL_W-1:0]    r_key_ctl;
    logic [irc_pkg::PH_W-1:0]     r_key_ph;
    irc_pkg::t_verdict            r_verdict, n_verdict;
    logic [irc_pkg::VERD_W-1:0]   r_out_verdict;
    logic                         w_full_match;

    assign o_stat.hit  = r_valid[r_idx] && (r_seq[r_idx] == r_key_seq);
    assign o_stat.last = (r_idx == LAST_IDX);
    assign w_full_match = (r_ctl[r_idx] == r_key_ctl) && (r_ph[r_idx] == r_key_ph);
    assign o_verdict   = r_out_verdict;

    always_comb begin
        n_verdict = r_verdict;
        if (i_cmd.accept) begin
            n_verdict = irc_pkg::VERDICT_NEW;
        end else if (i_cmd.scan && o_stat.hit) begin
            n_verdict = w_full_match ? irc_pkg::VERDICT_DUPLICATE : irc_pkg::VERDICT_CONFLICT;
        end
    end

    // valid marks and write pointer are control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_wptr  <= '0;
        end else if (i_cmd.clear) begin
            r_valid <= '0;
            r_wptr  <= '0;
        end else if (i_cmd.record) begin
            r_valid[r_wptr] <= 1'b1;
            r_wptr          <= (r_wptr == LAST_IDX) ? '0 : r_wptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.record) begin
            r_seq[r_wptr] <= i_seq_number;
            r_ctl[r_wptr] <= i_control_code;
            r_ph[r_wptr]  <= i_phase_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key_seq <= i_seq_number;
            r_key_ctl <= i_control_code;
            r_key_ph  <= i_phase_code;
            r_idx     <= '0;
        end else if (i_cmd.scan && !o_stat.last) begin
            r_idx <= r_idx + 1'b1;
        end
        r_verdict <= n_verdict;
        if (i_cmd.load_out) begin
            r_out_verdict <= r_verdict;
        end
    end

endmodule

FILE: hw/rtl/input_replay_cache_core.sv
// Input replay cache: replay-detection table for input events.
// Request channel i_req (sink): req_type lookup / record / clear, with
// seq_number, control_code and phase_code. Response channel o_rsp (source):
// one verdict per request (new, duplicate, conflict; new for record/clear).
// Lookup scans the 16-entry table one entry per cycle in index order and
// stops at the first valid entry with an equal sequence number or at the
// last entry, so 1 to 16 entries are examined. Record and clear act at the
// transfer and go from idle straight to the finish state with no scan.
// One request is in flight at a time; i_req.ready is high only while idle.
// The scan unit reading one table entry per cycle sets the lookup time.
// The result waits in an output register; if the receiver stalls, the block
// finishes the current request and then holds until the register is taken.
// Reset (i_rst_n, synchronous, active low) invalidates all entries, zeroes
// the write pointer and drops any pending result.
// Depends on irc_pkg, irc_req_if, irc_rsp_if, irc_ctrl and irc_dpath.

module input_replay_cache_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    irc_req_if.sink   i_req,
    irc_rsp_if.source o_rsp
);

    irc_pkg::t_cmd  w_cmd;
    irc_pkg::t_stat w_stat;

    irc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_req_type  (i_req.req_type),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (w_cmd)
    );

    irc_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_seq_number   (i_req.seq_number),
        .i_control_code (i_req.control_code),
        .i_phase_code   (i_req.phase_code),
        .o_stat         (w_stat),
        .o_verdict      (o_rsp.verdict)
    );

endmodule
